/* design/ihex_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types and codes of the HEX record loader: the character and result
// transaction layouts, parse phases, status codes and the hex digit decoder.
// ----------------------------------------------------------------------------
package ihex_pkg;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       stream_last;
	} char_item_t;

	typedef struct packed {
		logic        mem_write;
		logic [20:0] write_address;
		logic [7:0]  write_data;
		logic        record_end;
		logic        unsupported_type;
		logic [2:0]  status;
	} result_item_t;

	// Parse phases.
	localparam logic [2:0] PH_COLON = 3'd0;
	localparam logic [2:0] PH_LEN   = 3'd1;
	localparam logic [2:0] PH_OFS   = 3'd2;
	localparam logic [2:0] PH_TYPE  = 3'd3;
	localparam logic [2:0] PH_DATA  = 3'd4;
	localparam logic [2:0] PH_SEG   = 3'd5;
	localparam logic [2:0] PH_CSUM  = 3'd6;
	localparam logic [2:0] PH_SKIP  = 3'd7;

	// Status codes.
	localparam logic [2:0] ST_RUN   = 3'd0;
	localparam logic [2:0] ST_DONE  = 3'd1;
	localparam logic [2:0] ST_COLON = 3'd2;
	localparam logic [2:0] ST_DIGIT = 3'd3;
	localparam logic [2:0] ST_CSUM  = 3'd4;
	localparam logic [2:0] ST_NOEND = 3'd5;

	// Characters and record kinds.
	localparam logic [7:0] CHAR_COLON   = 8'h3A;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] KIND_DATA    = 8'h00;
	localparam logic [7:0] KIND_END     = 8'h01;
	localparam logic [7:0] KIND_SEGMENT = 8'h02;

	// Returns {valid, value}; valid is low when the character is not a hex digit.
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [7:0] u;
		logic [4:0] r;
		u = (c > 8'h39) ? (c & 8'hDF) : c;
		if (u >= 8'h30 && u <= 8'h39) begin
			r = {1'b1, u[3:0]};
		end else if (u >= 8'h41 && u <= 8'h46) begin
			r = {1'b1, 4'(u[3:0] + 4'd9)};
		end else begin
			r = 5'b0;
		end
		return r;
	endfunction

endpackage

/* design/ihex_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihex_parser
// Record parser state and its one-character update. The result for the
// character on item is formed combinationally; state advances when step is high.
// ----------------------------------------------------------------------------
module ihex_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  ihex_pkg::char_item_t  item,
	output ihex_pkg::result_item_t result
);

	logic [2:0]  phase_q, phase_n;
	logic [1:0]  dcount_q, dcount_n;
	logic [15:0] accum_q, accum_n;
	logic [7:0]  length_q, length_n;
	logic [15:0] offset_q, offset_n;
	logic [7:0]  kind_q, kind_n;
	logic [19:0] segment_q, segment_n;
	logic [7:0]  sum_q, sum_n;
	logic [7:0]  index_q, index_n;
	logic [2:0]  status_q, status_n;

	logic [4:0]  digit;
	logic        wide;
	logic [1:0]  count_inc;
	logic [15:0] accum_shift;
	logic        field_done;

	always_comb begin
		digit       = ihex_pkg::hex_decode(item.char_byte);
		wide        = (phase_q == ihex_pkg::PH_OFS) || (phase_q == ihex_pkg::PH_SEG);
		count_inc   = dcount_q + 2'd1;
		accum_shift = {accum_q[11:0], digit[3:0]};
		field_done  = wide ? (count_inc == 2'd0) : (count_inc == 2'd2);

		phase_n   = phase_q;
		dcount_n  = dcount_q;
		accum_n   = accum_q;
		length_n  = length_q;
		offset_n  = offset_q;
		kind_n    = kind_q;
		segment_n = segment_q;
		sum_n     = sum_q;
		index_n   = index_q;
		status_n  = status_q;
		result    = '0;

		if (status_q == ihex_pkg::ST_RUN) begin
			case (phase_q)
				ihex_pkg::PH_COLON: begin
					if (item.char_byte == ihex_pkg::CHAR_COLON) begin
						phase_n  = ihex_pkg::PH_LEN;
						dcount_n = 2'd0;
						accum_n  = '0;
						sum_n    = '0;
						index_n  = '0;
					end else begin
						status_n = ihex_pkg::ST_COLON;
					end
				end
				ihex_pkg::PH_SKIP: begin
					if (item.char_byte == ihex_pkg::CHAR_NEWLINE) begin
						phase_n = ihex_pkg::PH_COLON;
					end
				end
				default: begin
					if (!digit[4]) begin
						status_n = ihex_pkg::ST_DIGIT;
					end else begin
						dcount_n = count_inc;
						accum_n  = accum_shift;
						if (field_done) begin
							dcount_n = 2'd0;
							accum_n  = '0;
							sum_n    = sum_q + accum_shift[15:8] + accum_shift[7:0];
							case (phase_q)
								ihex_pkg::PH_LEN: begin
									length_n = accum_shift[7:0];
									phase_n  = ihex_pkg::PH_OFS;
								end
								ihex_pkg::PH_OFS: begin
									offset_n = accum_shift;
									phase_n  = ihex_pkg::PH_TYPE;
								end
								ihex_pkg::PH_TYPE: begin
									kind_n = accum_shift[7:0];
									if (accum_shift[7:0] == ihex_pkg::KIND_DATA) begin
										phase_n = (length_q == 8'd0) ? ihex_pkg::PH_CSUM
											: ihex_pkg::PH_DATA;
									end else if (accum_shift[7:0] == ihex_pkg::KIND_SEGMENT) begin
										phase_n = ihex_pkg::PH_SEG;
									end else begin
										phase_n = ihex_pkg::PH_CSUM;
									end
								end
								ihex_pkg::PH_DATA: begin
									result.mem_write     = 1'b1;
									result.write_address = {1'b0, segment_q} + 21'(offset_q)
										+ 21'(index_q);
									result.write_data    = accum_shift[7:0];
									index_n = index_q + 8'd1;
									if (index_n == length_q) begin
										phase_n = ihex_pkg::PH_CSUM;
									end
								end
								ihex_pkg::PH_SEG: begin
									segment_n = {accum_shift, 4'b0};
									phase_n   = ihex_pkg::PH_CSUM;
								end
								default: begin
									if (sum_n != 8'd0) begin
										status_n = ihex_pkg::ST_CSUM;
									end else begin
										result.record_end = 1'b1;
										if (kind_q == ihex_pkg::KIND_END) begin
											status_n = ihex_pkg::ST_DONE;
										end else if (kind_q != ihex_pkg::KIND_DATA
											&& kind_q != ihex_pkg::KIND_SEGMENT) begin
											result.unsupported_type = 1'b1;
										end
										phase_n = ihex_pkg::PH_SKIP;
									end
								end
							endcase
						end
					end
				end
			endcase
			if (item.stream_last && status_n == ihex_pkg::ST_RUN) begin
				status_n = ihex_pkg::ST_NOEND;
			end
		end
		result.status = status_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= ihex_pkg::PH_COLON;
			dcount_q  <= '0;
			accum_q   <= '0;
			length_q  <= '0;
			offset_q  <= '0;
			kind_q    <= '0;
			segment_q <= '0;
			sum_q     <= '0;
			index_q   <= '0;
			status_q  <= ihex_pkg::ST_RUN;
		end else if (step) begin
			phase_q   <= phase_n;
			dcount_q  <= dcount_n;
			accum_q   <= accum_n;
			length_q  <= length_n;
			offset_q  <= offset_n;
			kind_q    <= kind_n;
			segment_q <= segment_n;
			sum_q     <= sum_n;
			index_q   <= index_n;
			status_q  <= status_n;
		end
	end

endmodule

/* design/intel_hex_record_loader_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intel_hex_record_loader_unit
// Parses HEX text one character per transaction and returns one result per
// character: a memory byte write, a record-end flag and a sticky status.
// ----------------------------------------------------------------------------
//
//   Channel  | Direction | Payload                  | Handshake
//   ---------+-----------+--------------------------+---------------------------
//   char     | in        | char_byte, stream_last   | char_valid / char_stall
//   res      | out       | write, flags, status     | res_valid / res_stall
//
// One character is taken per clock cycle while char_stall is low; its result
// is registered in the output register, or in the skid register. The parser's
// state update sets the rate (digit decode, checksum add and the 21-bit
// address add). Reset is asynchronous and needs no clearing pass. A stalled
// result transaction is held in the output register while one more character
// is taken into a skid register; char_stall rises only when the skid is full.
// ----------------------------------------------------------------------------
module intel_hex_record_loader_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   char_valid,
	output logic                   char_stall,
	input  ihex_pkg::char_item_t   char_data,
	output logic                   res_valid,
	input  logic                   res_stall,
	output ihex_pkg::result_item_t res_data
);

	logic                   step;
	logic                   take_out;
	ihex_pkg::result_item_t step_result;

	logic                   out_valid_q;
	ihex_pkg::result_item_t out_q;
	logic                   skid_valid_q;
	ihex_pkg::result_item_t skid_q;

	// A character transaction completes whenever the skid register is free.
	assign char_stall = skid_valid_q;
	assign step       = char_valid && !char_stall;
	assign take_out   = out_valid_q && !res_stall;

	ihex_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (char_data),
		.result (step_result)
	);

	// Valid flags of the output register and the skid register. The skid is
	// only ever filled while the output register holds a stalled result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (take_out) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= step;
				end
			end else if (!out_valid_q) begin
				out_valid_q <= step;
			end else if (step) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// Payload registers follow the same decisions and need no reset.
	always_ff @(posedge clk) begin
		if (take_out) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (step) begin
				out_q <= step_result;
			end
		end else if (!out_valid_q) begin
			if (step) begin
				out_q <= step_result;
			end
		end else if (step) begin
			skid_q <= step_result;
		end
	end

	assign res_valid = out_valid_q;
	assign res_data  = out_q;

endmodule

/* design/ihex_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihex_checker
// Port-level checks of the HEX record loader, attached to the top level by
// a bind statement.
// ----------------------------------------------------------------------------
module ihex_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   char_stall,
	input logic                   res_valid,
	input logic                   res_stall,
	input ihex_pkg::result_item_t res_data
);

	logic       seen_q;
	logic [2:0] last_status_q;

	// Status of the last delivered result transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q        <= 1'b0;
			last_status_q <= ihex_pkg::ST_RUN;
		end else if (res_valid && !res_stall) begin
			seen_q        <= 1'b1;
			last_status_q <= res_data.status;
		end
	end

	// A stalled result holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("stalled result changed");

	// Once a final status is delivered, every later result carries it.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && seen_q && last_status_q != ihex_pkg::ST_RUN
		|-> res_data.status == last_status_q && !res_data.mem_write)
		else $error("status not sticky");

	// An unsupported type is only reported on a record end, never with a write.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.unsupported_type |-> res_data.record_end)
		else $error("unsupported type without record end");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.mem_write |-> !res_data.record_end)
		else $error("write and record end together");

	// Input is never held off while no result is waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> !char_stall)
		else $error("input stalled with empty output");

endmodule

bind intel_hex_record_loader_unit ihex_checker u_ihex_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.char_stall (char_stall),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.res_data   (res_data)
);
